/* rtl/alr_pkg.sv */
// ----------------------------------------------------------------------------
// alr_pkg - shared definitions for the antialiased line rasterizer
// Default sizes, register map, item opcodes, configuration bundle and the
// width of the command word between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package alr_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIFO_DEPTH_DEF = 4;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // register index, taken from paddr[4:2]
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_COLOUR_RED   = 3'd2;
    localparam logic [2:0] REG_COLOUR_GREEN = 3'd3;
    localparam logic [2:0] REG_COLOUR_BLUE  = 3'd4;
    localparam logic [2:0] REG_COLOUR_ALPHA = 3'd5;

    localparam logic [7:0] ALPHA_RESET = 8'd127;

    // item opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic [14:0] frame_width;
        logic [14:0] frame_height;
        logic [7:0]  colour_red;
        logic [7:0]  colour_green;
        logic [7:0]  colour_blue;
        logic [7:0]  colour_alpha;
    } t_cfg;

    // command word: op, steep, dy sign, a0, b0, a1, b1, |dx|, |dy|
    function automatic int cmd_width(input int coord_bits);
        return 6 * coord_bits + 5;
    endfunction

endpackage

`default_nettype wire

/* rtl/alr_front.sv */
// ----------------------------------------------------------------------------
// alr_front - input pipe and line classifier
// Takes items from the input stream, finds the steep axis, orders the
// endpoints along the major axis and pushes one command word per item.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_front #(
    parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
    parameter int CMD_W      = alr_pkg::cmd_width(alr_pkg::COORD_BITS_DEF)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_op,
    input  logic [COORD_BITS-1:0] i_x0,
    input  logic [COORD_BITS-1:0] i_y0,
    input  logic [COORD_BITS-1:0] i_x1,
    input  logic [COORD_BITS-1:0] i_y1,
    output logic                  o_push,
    input  logic                  i_full,
    output logic [CMD_W-1:0]      o_cmd
);
    import alr_pkg::*;

    localparam int C = COORD_BITS;

    // stage 1: raw item and endpoint differences
    logic                r_s1_v;
    logic                r_s1_op;
    logic [C-1:0]        r_s1_x0, r_s1_y0, r_s1_x1, r_s1_y1;
    logic signed [C:0]   r_s1_dx, r_s1_dy;

    // stage 2: classified command
    logic                r_s2_v;
    logic                r_s2_op, r_s2_steep, r_s2_dy_neg;
    logic [C-1:0]        r_s2_a0, r_s2_b0, r_s2_a1, r_s2_b1;
    logic [C:0]          r_s2_dx, r_s2_dy_abs;

    logic s1_load, s2_load;
    logic [C:0] abs_dx, abs_dy, abs_maj, abs_min;
    logic signed [C:0] d_maj, d_min;
    logic steep, swap;
    logic [C-1:0] maj0, maj1, min0, min1;

    assign o_push  = r_s2_v && !i_full;
    assign s2_load = !r_s2_v || o_push;
    assign s1_load = !r_s1_v || s2_load;
    assign o_ready = s1_load;

    always_comb begin
        abs_dx = r_s1_dx[C] ? (~r_s1_dx + (C+1)'(1)) : r_s1_dx;
        abs_dy = r_s1_dy[C] ? (~r_s1_dy + (C+1)'(1)) : r_s1_dy;
        steep  = abs_dy > abs_dx;
        d_maj   = steep ? r_s1_dy : r_s1_dx;
        d_min   = steep ? r_s1_dx : r_s1_dy;
        abs_maj = steep ? abs_dy : abs_dx;
        abs_min = steep ? abs_dx : abs_dy;
        maj0 = steep ? r_s1_y0 : r_s1_x0;
        maj1 = steep ? r_s1_y1 : r_s1_x1;
        min0 = steep ? r_s1_x0 : r_s1_y0;
        min1 = steep ? r_s1_x1 : r_s1_y1;
        // endpoints run backward along the major axis: swap them
        swap = d_maj[C];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_v <= i_valid;
            end
            if (s2_load) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_valid) begin
            r_s1_op <= i_op;
            r_s1_x0 <= i_x0;
            r_s1_y0 <= i_y0;
            r_s1_x1 <= i_x1;
            r_s1_y1 <= i_y1;
            r_s1_dx <= {i_x1[C-1], i_x1} - {i_x0[C-1], i_x0};
            r_s1_dy <= {i_y1[C-1], i_y1} - {i_y0[C-1], i_y0};
        end
        if (s2_load && r_s1_v) begin
            r_s2_op     <= r_s1_op;
            r_s2_steep  <= steep;
            r_s2_dy_neg <= d_min[C] ^ swap;
            r_s2_a0     <= swap ? maj1 : maj0;
            r_s2_b0     <= swap ? min1 : min0;
            r_s2_a1     <= swap ? maj0 : maj1;
            r_s2_b1     <= swap ? min0 : min1;
            r_s2_dx     <= abs_maj;
            r_s2_dy_abs <= abs_min;
        end
    end

    assign o_cmd = {r_s2_dy_abs, r_s2_dx, r_s2_b1, r_s2_a1, r_s2_b0, r_s2_a0,
                    r_s2_dy_neg, r_s2_steep, r_s2_op};

endmodule

`default_nettype wire

/* rtl/alr_fifo.sv */
// ----------------------------------------------------------------------------
// alr_fifo - command queue
// Short first-in first-out queue that decouples the classifier from the
// pixel sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_fifo #(
    parameter int WIDTH = alr_pkg::cmd_width(alr_pkg::COORD_BITS_DEF),
    parameter int DEPTH = alr_pkg::FIFO_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import alr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/alr_back.sv */
// ----------------------------------------------------------------------------
// alr_back - line state, gradient divider and pixel sequencer
// Pops commands, divides dy by dx one quotient bit per cycle on a start,
// walks the intercept on a step and sends the two pixels of each item that does work.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_back #(
    parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF,
    parameter int CMD_W      = alr_pkg::cmd_width(alr_pkg::COORD_BITS_DEF)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic                  i_empty,
    output logic                  o_pop,
    input  alr_pkg::t_cfg         i_cfg,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic [7:0]            o_alpha,
    output logic                  o_visible,
    output logic                  o_last,
    output logic                  o_done
);
    import alr_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int AW    = C + F + 1;
    localparam int GW    = F + 2;
    localparam int CNT_W = $clog2(F + 1);
    localparam int VW    = (C + 2 > 17) ? C + 2 : 17;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_INIT = 5'b00100,
        S_PIX0 = 5'b01000,
        S_PIX1 = 5'b10000
    } t_state;

    // command fields
    logic         c_op, c_steep, c_dy_neg;
    logic [C-1:0] c_a0, c_b0, c_a1, c_b1;
    logic [C:0]   c_dx, c_dy_abs;

    assign c_op     = i_cmd[0];
    assign c_steep  = i_cmd[1];
    assign c_dy_neg = i_cmd[2];
    assign c_a0     = i_cmd[3 +: C];
    assign c_b0     = i_cmd[3 + C +: C];
    assign c_a1     = i_cmd[3 + 2*C +: C];
    assign c_b1     = i_cmd[3 + 3*C +: C];
    assign c_dx     = i_cmd[3 + 4*C +: C + 1];
    assign c_dy_abs = i_cmd[4 + 5*C +: C + 1];

    t_state r_state, n_state;
    logic                 r_steep, r_active, r_dy_neg;
    logic signed [C:0]    r_cur, r_last;
    logic signed [AW-1:0] r_acc;
    logic signed [GW-1:0] r_grad;
    logic [C:0]           r_rem, r_dx;
    logic [F:0]           r_q;
    logic [CNT_W-1:0]     r_cnt;
    logic [C-1:0]         r_a0, r_b0, r_a1, r_b1;
    logic signed [C:0]    r_pmaj [2];
    logic signed [C:0]    r_pmin [2];
    logic [F:0]           r_pcov [2];
    logic                 r_pdone;

    logic         r_ov;
    logic [C-1:0] r_px, r_py;
    logic [7:0]   r_red, r_green, r_blue, r_alpha;
    logic         r_vis, r_last_beat, r_done_beat;

    logic take_start, take_step, div_ge, div_end, step_more;
    logic out_free, out_load, out_sel;
    logic [C:0] div_sub, div_keep;
    logic [F-1:0] step_frac;
    logic signed [C:0] step_ipart;
    logic [F:0] grad_mag, cov_full;
    logic signed [GW-1:0] grad_pos;
    logic signed [AW-1:0] init_base, mag_ext;
    logic signed [C:0] sel_maj, sel_min, pix_x, pix_y;
    logic [F:0] sel_cov;
    logic signed [VW-1:0] vis_x, vis_y, vis_w, vis_h;
    logic [F+8:0] alpha_prod;

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign take_start = o_pop && (c_op == OP_START);
    assign take_step  = o_pop && (c_op == OP_STEP) && r_active;

    // restoring divider, one quotient bit per cycle
    assign div_ge   = r_rem >= r_dx;
    assign div_sub  = r_rem - r_dx;
    assign div_keep = div_ge ? div_sub : r_rem;
    assign div_end  = r_cnt == CNT_W'(F);

    assign step_frac  = r_acc[F-1:0];
    assign step_ipart = r_acc[AW-1:F];
    assign step_more  = r_cur < r_last;

    assign cov_full  = {1'b1, {F{1'b0}}};
    assign grad_mag  = (r_dx == '0) ? '0 : r_q;
    assign grad_pos  = $signed({1'b0, grad_mag});
    assign mag_ext   = $signed({{(AW-F-1){1'b0}}, grad_mag});
    assign init_base = $signed({r_b0[C-1], r_b0, {F{1'b0}}});

    // output register: load when empty or draining
    assign out_free = !r_ov || i_out_ready;
    assign out_sel  = r_state == S_PIX1;
    assign out_load = ((r_state == S_PIX0) || (r_state == S_PIX1)) && out_free;

    always_comb begin
        sel_maj = out_sel ? r_pmaj[1] : r_pmaj[0];
        sel_min = out_sel ? r_pmin[1] : r_pmin[0];
        sel_cov = out_sel ? r_pcov[1] : r_pcov[0];
        pix_x   = r_steep ? sel_min : sel_maj;
        pix_y   = r_steep ? sel_maj : sel_min;
        vis_x   = {{(VW-C-1){pix_x[C]}}, pix_x};
        vis_y   = {{(VW-C-1){pix_y[C]}}, pix_y};
        vis_w   = {{(VW-15){1'b0}}, i_cfg.frame_width};
        vis_h   = {{(VW-15){1'b0}}, i_cfg.frame_height};
        alpha_prod = i_cfg.colour_alpha * sel_cov;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take_start) begin
                    n_state = S_DIV;
                end else if (take_step) begin
                    n_state = S_PIX0;
                end
            end
            S_DIV: begin
                if (div_end) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_state = S_PIX0;
            end
            S_PIX0: begin
                if (out_free) begin
                    n_state = S_PIX1;
                end
            end
            S_PIX1: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_cnt    <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take_start) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (take_step) begin
                r_active <= step_more;
            end else if (r_state == S_INIT) begin
                r_active <= r_dx >= (C+1)'(2);
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_start) begin
            r_steep  <= c_steep;
            r_a0     <= c_a0;
            r_b0     <= c_b0;
            r_a1     <= c_a1;
            r_b1     <= c_b1;
            r_dx     <= c_dx;
            r_dy_neg <= c_dy_neg;
            r_rem    <= c_dy_abs;
            r_q      <= '0;
        end
        if (r_state == S_DIV) begin
            r_rem <= {div_keep[C-1:0], 1'b0};
            r_q   <= {r_q[F-1:0], div_ge};
        end
        if (take_step) begin
            r_pmaj[0] <= r_cur;
            r_pmaj[1] <= r_cur;
            r_pmin[0] <= step_ipart;
            r_pmin[1] <= step_ipart + (C+1)'(1);
            r_pcov[0] <= cov_full - {1'b0, step_frac};
            r_pcov[1] <= {1'b0, step_frac};
            r_pdone   <= !step_more;
            r_acc     <= r_acc + {{(AW-GW){r_grad[GW-1]}}, r_grad};
            r_cur     <= r_cur + (C+1)'(1);
        end
        if (r_state == S_INIT) begin
            r_grad    <= r_dy_neg ? -grad_pos : grad_pos;
            r_acc     <= r_dy_neg ? init_base - mag_ext : init_base + mag_ext;
            r_cur     <= {r_a0[C-1], r_a0} + (C+1)'(1);
            r_last    <= {r_a1[C-1], r_a1} - (C+1)'(1);
            r_pmaj[0] <= {r_a0[C-1], r_a0};
            r_pmin[0] <= {r_b0[C-1], r_b0};
            r_pmaj[1] <= {r_a1[C-1], r_a1};
            r_pmin[1] <= {r_b1[C-1], r_b1};
            r_pcov[0] <= cov_full;
            r_pcov[1] <= cov_full;
            r_pdone   <= r_dx < (C+1)'(2);
        end
        if (out_load) begin
            r_px        <= pix_x[C-1:0];
            r_py        <= pix_y[C-1:0];
            r_red       <= i_cfg.colour_red;
            r_green     <= i_cfg.colour_green;
            r_blue      <= i_cfg.colour_blue;
            r_alpha     <= alpha_prod[F+7:F];
            r_vis       <= (vis_x < vis_w) && (vis_y < vis_h);
            r_last_beat <= out_sel;
            r_done_beat <= r_pdone;
        end
    end

    assign o_out_valid = r_ov;
    assign o_pixel_x   = r_px;
    assign o_pixel_y   = r_py;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_alpha     = r_alpha;
    assign o_visible   = r_vis;
    assign o_last      = r_last_beat;
    assign o_done      = r_done_beat;

endmodule

`default_nettype wire

/* rtl/antialiased_line_rasterizer_top.sv */
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_top - antialiased line rasterizer
// Wu-style line walker: a start item sets up a line, each step item
// yields the two coverage-weighted pixels of the next column.
// ----------------------------------------------------------------------------
// Using the block: send a start item (tuser = 0) with both endpoints, then
// one step item (tuser = 1) per interior column. Every item that does work
// returns a pair of pixel items; tlast marks the second one of the pair and
// tuser[1] goes high once no interior column is left. Steps sent with no
// line in progress are dropped without output. For a start item the back
// end pops it, runs the bit-serial gradient divider, sets up and sends
// two output beats; for a step item it pops it and sends two output beats
// through the single output register. Items enter through a two-stage
// classifier and a FIFO_DEPTH-entry command queue, so input keeps flowing
// while the back end divides or the output is stalled, until the queue
// fills. Configuration registers sit on the APB port at byte address
// 4 * index and are only to be written while the block is idle.
`default_nettype none

module antialiased_line_rasterizer_top #(
    parameter int  COORD_BITS = alr_pkg::COORD_BITS_DEF,
    parameter int  FRAC_BITS  = alr_pkg::FRAC_BITS_DEF,
    parameter int  FIFO_DEPTH = alr_pkg::FIFO_DEPTH_DEF,
    localparam int IN_W       = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((2 * COORD_BITS + 32 + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [alr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [alr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [alr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    // input items
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [IN_W-1:0]                s_axis_tdata,  // start_x, start_y, end_x, end_y
    input  logic [0:0]                     s_axis_tuser,  // op
    // pixel items
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [OUT_W-1:0]               m_axis_tdata,  // pixel_x, pixel_y, red, green,
                                                          // blue, alpha
    output logic [1:0]                     m_axis_tuser,  // visible, line_done
    output logic                           m_axis_tlast   // last_of_run
);
    import alr_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int CMD_W = cmd_width(COORD_BITS);

    t_cfg r_cfg;
    logic cfg_wr;
    logic [2:0] cfg_idx;

    logic             push, full, pop, empty;
    logic [CMD_W-1:0] cmd_in, cmd_out;

    logic [C-1:0] px, py;
    logic [7:0]   red, green, blue, alpha;
    logic         visible, last_beat, done;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= '0;
            r_cfg.frame_height <= '0;
            r_cfg.colour_red   <= '0;
            r_cfg.colour_green <= '0;
            r_cfg.colour_blue  <= '0;
            r_cfg.colour_alpha <= ALPHA_RESET;
        end else if (cfg_wr) begin
            // drop writes to unmapped indexes
            unique case (cfg_idx)
                REG_FRAME_WIDTH:  r_cfg.frame_width  <= pwdata[14:0];
                REG_FRAME_HEIGHT: r_cfg.frame_height <= pwdata[14:0];
                REG_COLOUR_RED:   r_cfg.colour_red   <= pwdata[7:0];
                REG_COLOUR_GREEN: r_cfg.colour_green <= pwdata[7:0];
                REG_COLOUR_BLUE:  r_cfg.colour_blue  <= pwdata[7:0];
                REG_COLOUR_ALPHA: r_cfg.colour_alpha <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata[14:0] = r_cfg.frame_width;
            REG_FRAME_HEIGHT: prdata[14:0] = r_cfg.frame_height;
            REG_COLOUR_RED:   prdata[7:0]  = r_cfg.colour_red;
            REG_COLOUR_GREEN: prdata[7:0]  = r_cfg.colour_green;
            REG_COLOUR_BLUE:  prdata[7:0]  = r_cfg.colour_blue;
            REG_COLOUR_ALPHA: prdata[7:0]  = r_cfg.colour_alpha;
            default: begin
            end
        endcase
    end

    // ---------------- front end: accept and classify ----------------
    alr_front #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser[0]),
        .i_x0    (s_axis_tdata[0 +: C]),
        .i_y0    (s_axis_tdata[C +: C]),
        .i_x1    (s_axis_tdata[2*C +: C]),
        .i_y1    (s_axis_tdata[3*C +: C]),
        .o_push  (push),
        .i_full  (full),
        .o_cmd   (cmd_in)
    );

    // ---------------- command queue ----------------
    alr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (cmd_out),
        .o_empty (empty)
    );

    // ---------------- back end: divide, walk, emit ----------------
    alr_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_cfg       (r_cfg),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_pixel_x   (px),
        .o_pixel_y   (py),
        .o_red       (red),
        .o_green     (green),
        .o_blue      (blue),
        .o_alpha     (alpha),
        .o_visible   (visible),
        .o_last      (last_beat),
        .o_done      (done)
    );

    // pack the pixel item, zero fill up to a whole byte
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[0 +: C]        = px;
        m_axis_tdata[C +: C]        = py;
        m_axis_tdata[2*C +: 8]      = red;
        m_axis_tdata[2*C + 8 +: 8]  = green;
        m_axis_tdata[2*C + 16 +: 8] = blue;
        m_axis_tdata[2*C + 24 +: 8] = alpha;
    end

    assign m_axis_tuser = {done, visible};
    assign m_axis_tlast = last_beat;

endmodule

`default_nettype wire

/* rtl/alr_checker.sv */
// ----------------------------------------------------------------------------
// alr_checker - port-level checks for the line rasterizer
// Watches the pixel stream: pairing of beats, line_done within a pair,
// a held tvalid while stalled, and a quiet output after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic       m_axis_tlast,
    input logic [1:0] m_axis_tuser
);
    logic out_acc;
    logic r_half;
    logic r_done0;

    assign out_acc = m_axis_tvalid && m_axis_tready;

    // track the first beat of a pixel pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
        end else if (out_acc) begin
            r_half <= !m_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc && !m_axis_tlast) begin
            r_done0 <= m_axis_tuser[1];
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("pixel beat dropped while stalled");

    a_second_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && m_axis_tlast |-> r_half)
        else $error("second pixel without a first");

    a_first_after_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !m_axis_tlast |-> !r_half)
        else $error("first pixel while a pair is open");

    a_done_in_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && m_axis_tlast |-> m_axis_tuser[1] == r_done0)
        else $error("line_done differs within a pixel pair");

    a_quiet_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("pixel beat right after reset");

endmodule

bind antialiased_line_rasterizer_top alr_checker u_alr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
